### rtl/core/salc_pkg.sv
// shared types, constants and register codes for the set-associative lru cache simulator
`default_nettype none

package salc_pkg;

   // default geometry
   localparam int MAX_SET_BITS_DEF = 6;
   localparam int WAYS_DEF         = 8;
   localparam int ADDR_BITS        = 32;

   // address bits that take part in the lookup
   localparam logic [31:0] ADDR_MASK = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF :
                                       32'((64'd1 << ADDR_BITS) - 64'd1);

   // access kinds
   localparam logic [1:0] FUNC_INSTR  = 2'd0;
   localparam logic [1:0] FUNC_LOAD   = 2'd1;
   localparam logic [1:0] FUNC_STORE  = 2'd2;
   localparam logic [1:0] FUNC_MODIFY = 2'd3;

   // control register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS_IN_USE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BITS  = 2'd2;

   localparam logic [2:0] SET_BITS_RST    = 3'd4;
   localparam logic [3:0] WAYS_IN_USE_RST = 4'd1;
   localparam logic [4:0] BLOCK_BITS_RST  = 5'd4;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] address;
   } req_word_type;

   typedef struct packed {
      logic        touched;
      logic        hit;
      logic        miss;
      logic        eviction;
      logic [2:0]  way_used;
      logic [31:0] hit_total;
      logic [31:0] miss_total;
      logic [31:0] eviction_total;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic clear_step;
      logic capture;
      logic read;
      logic eval;
      logic commit;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

### rtl/core/set_assoc_lru_cache_sim.sv
// Set-associative cache hit/miss model with true LRU replacement. After reset a clearing
// pass walks all 2**MAX_SET_BITS sets (64 at the default), one set per cycle, with
// req_ready low; control register writes are taken throughout. Each access then
// goes through these steps: the accepting edge captures the word, then come the set row
// read, the tag compare and victim choice, and the write back of the row and counters,
// which loads the result word into the output register once that register is free. One
// access is in flight at a time because every access is a read-modify-write of its set
// row, so a new access is accepted only after the previous one has written back. The
// result register lets the next access be accepted while the previous result waits.
// Instruction and modify accesses pass through the same steps and return all-zero flags.
`default_nettype none

module set_assoc_lru_cache_sim #(
   parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
   parameter int WAYS         = salc_pkg::WAYS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire salc_pkg::req_word_type              req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output salc_pkg::rsp_word_type                   rsp_data,
   input  wire logic                                csr_we,
   input  wire logic [salc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [salc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   salc_pkg::ctrl_cmd_type  cmd;
   salc_pkg::dp_status_type status;

   salc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   salc_dpath #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .WAYS         (WAYS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

`default_nettype wire

### rtl/core/salc_ctrl.sv
// sequencing state machine: clearing pass, capture, set read, evaluate, write back
`default_nettype none

module salc_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire salc_pkg::dp_status_type status,
   output salc_pkg::ctrl_cmd_type       cmd
);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_EVAL  = 5'b01000,
      ST_WRITE = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            // hold until the result register can take the word
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/salc_dpath.sv
// set memories, tag compare, lru ranking, counters, control registers and result register
`default_nettype none

module salc_dpath #(
   parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
   parameter int WAYS         = salc_pkg::WAYS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire salc_pkg::ctrl_cmd_type              cmd,
   output salc_pkg::dp_status_type                  status,
   input  wire salc_pkg::req_word_type              req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output salc_pkg::rsp_word_type                   rsp_data,
   input  wire logic                                csr_we,
   input  wire logic [salc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [salc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int NSETS     = 1 << MAX_SET_BITS;
   localparam int SET_IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int WCNT_W    = $clog2(WAYS + 1);

   // set memories, one row per set
   logic [WAYS-1:0]             valid_mem [NSETS];
   logic [WAYS-1:0][WAY_W-1:0]  rank_mem  [NSETS];
   logic [WAYS-1:0][31:0]       tag_mem   [NSETS];

   logic [WAYS-1:0]             valid_rd_ff;
   logic [WAYS-1:0][WAY_W-1:0]  rank_rd_ff;
   logic [WAYS-1:0][31:0]       tag_rd_ff;

   // control registers
   logic [2:0] set_bits_ff;
   logic [3:0] ways_in_use_ff;
   logic [4:0] block_bits_ff;

   salc_pkg::req_word_type req_ff;
   logic                   touched_ff;
   logic [SET_IDX_W-1:0]   set_ff;
   logic [31:0]            tag_ff;

   logic                   ev_hit_ff;
   logic                   ev_evict_ff;
   logic [WAY_W-1:0]       ev_way_ff;

   logic [SET_IDX_W-1:0]   clr_idx_ff;

   logic [31:0]            hit_cnt_ff;
   logic [31:0]            miss_cnt_ff;
   logic [31:0]            evict_cnt_ff;

   logic                   rsp_valid_ff;
   salc_pkg::rsp_word_type rsp_ff;

   function automatic logic [WAY_W-1:0] way_index(input logic [WAYS-1:0] oh);
      logic [WAY_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < WAYS; i++) begin
         if (oh[i]) begin
            idx = idx | WAY_W'(i);
         end
      end
      return idx;
   endfunction

   // ---------------- address split
   logic [31:0]          addr_eff;
   logic [2:0]           s_eff;
   logic [7:0]           set_mask;
   logic [31:0]          set_full;
   logic [31:0]          set_val;
   logic [5:0]           tag_shift;
   logic [31:0]          tag_in;
   logic [SET_IDX_W-1:0] set_in;
   logic                 touched_in;

   always_comb begin
      addr_eff   = req_ff.address & salc_pkg::ADDR_MASK;
      s_eff      = ({1'b0, set_bits_ff} > 4'(MAX_SET_BITS)) ? 3'(MAX_SET_BITS) : set_bits_ff;
      set_mask   = 8'((9'd1 << s_eff) - 9'd1);
      set_full   = addr_eff >> block_bits_ff;
      set_val    = set_full & {24'd0, set_mask};
      set_in     = set_val[SET_IDX_W-1:0];
      tag_shift  = 6'(s_eff) + 6'(block_bits_ff);
      tag_in     = addr_eff >> tag_shift;
      touched_in = (req_ff.func == salc_pkg::FUNC_LOAD) ||
                   (req_ff.func == salc_pkg::FUNC_STORE);
   end

   // ---------------- ways in use
   logic [4:0]        ways_ext;
   logic [WCNT_W-1:0] ways_eff;
   logic [WAYS-1:0]   in_use;

   always_comb begin
      ways_ext = {1'b0, ways_in_use_ff};
      if (ways_ext == 5'd0) begin
         ways_eff = WCNT_W'(1);
      end else if (ways_ext > 5'(WAYS)) begin
         ways_eff = WCNT_W'(WAYS);
      end else begin
         ways_eff = WCNT_W'(ways_ext);
      end
      for (int i = 0; i < WAYS; i++) begin
         in_use[i] = (WCNT_W'(i) < ways_eff);
      end
   end

   // ---------------- evaluate on the registered row
   logic [WAYS-1:0]  match_vec;
   logic [WAYS-1:0]  empty_vec;
   logic [WAYS-1:0]  victim_vec;
   logic [WAYS-1:0]  match_first;
   logic [WAYS-1:0]  empty_first;
   logic             hit_in;
   logic             evict_in;
   logic [WAY_W-1:0] way_in;

   always_comb begin
      for (int i = 0; i < WAYS; i++) begin
         match_vec[i]  = in_use[i] && valid_rd_ff[i] && (tag_rd_ff[i] == tag_ff);
         empty_vec[i]  = in_use[i] && !valid_rd_ff[i];
         // highest rank wins, lowest way on a tie
         victim_vec[i] = in_use[i];
         for (int j = 0; j < WAYS; j++) begin
            if (in_use[j] && (j < i) && !(rank_rd_ff[j] < rank_rd_ff[i])) begin
               victim_vec[i] = 1'b0;
            end
            if (in_use[j] && (j > i) && (rank_rd_ff[j] > rank_rd_ff[i])) begin
               victim_vec[i] = 1'b0;
            end
         end
      end
      match_first = match_vec & (~match_vec + WAYS'(1));
      empty_first = empty_vec & (~empty_vec + WAYS'(1));
      hit_in      = touched_ff && (match_vec != '0);
      evict_in    = touched_ff && (match_vec == '0) && (empty_vec == '0);
      if (match_vec != '0) begin
         way_in = way_index(match_first);
      end else if (empty_vec != '0) begin
         way_in = way_index(empty_first);
      end else begin
         way_in = way_index(victim_vec);
      end
   end

   // ---------------- write back row
   logic                        fill;
   logic [WAY_W-1:0]            rank_old;
   logic [WAYS-1:0]             valid_new;
   logic [WAYS-1:0][WAY_W-1:0]  rank_new;
   logic [WAYS-1:0][31:0]       tag_new;

   always_comb begin
      fill      = touched_ff && !ev_hit_ff;
      rank_old  = rank_rd_ff[ev_way_ff];
      valid_new = valid_rd_ff;
      tag_new   = tag_rd_ff;
      rank_new  = rank_rd_ff;
      for (int i = 0; i < WAYS; i++) begin
         if (WAY_W'(i) == ev_way_ff) begin
            rank_new[i] = '0;
            if (fill) begin
               valid_new[i] = 1'b1;
               tag_new[i]   = tag_ff;
            end
         end else if (in_use[i] && valid_rd_ff[i] &&
                      (fill || (rank_rd_ff[i] < rank_old)) &&
                      (rank_rd_ff[i] != WAY_W'(WAYS - 1))) begin
            rank_new[i] = rank_rd_ff[i] + WAY_W'(1);
         end
      end
   end

   // ---------------- memories
   logic                 mem_we;
   logic [SET_IDX_W-1:0] mem_waddr;

   assign mem_we    = cmd.clear_step || (cmd.commit && touched_ff);
   assign mem_waddr = cmd.clear_step ? clr_idx_ff : set_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         valid_mem[mem_waddr] <= cmd.clear_step ? '0 : valid_new;
         rank_mem[mem_waddr]  <= cmd.clear_step ? '0 : rank_new;
         tag_mem[mem_waddr]   <= cmd.clear_step ? '0 : tag_new;
      end
      if (cmd.read) begin
         valid_rd_ff <= valid_mem[set_in];
         rank_rd_ff  <= rank_mem[set_in];
         tag_rd_ff   <= tag_mem[set_in];
      end
   end

   // ---------------- payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.read) begin
         set_ff     <= set_in;
         tag_ff     <= tag_in;
         touched_ff <= touched_in;
      end
      if (cmd.eval) begin
         ev_hit_ff   <= hit_in;
         ev_evict_ff <= evict_in;
         ev_way_ff   <= way_in;
      end
   end

   // ---------------- counters and result
   logic [31:0] hit_cnt_in;
   logic [31:0] miss_cnt_in;
   logic [31:0] evict_cnt_in;
   logic        inc_hit;
   logic        inc_miss;
   logic        inc_evict;

   always_comb begin
      inc_hit      = cmd.commit && touched_ff && ev_hit_ff;
      inc_miss     = cmd.commit && fill;
      inc_evict    = cmd.commit && fill && ev_evict_ff;
      hit_cnt_in   = hit_cnt_ff   + 32'(inc_hit   && (hit_cnt_ff   != '1));
      miss_cnt_in  = miss_cnt_ff  + 32'(inc_miss  && (miss_cnt_ff  != '1));
      evict_cnt_in = evict_cnt_ff + 32'(inc_evict && (evict_cnt_ff != '1));
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff.touched        <= touched_ff;
         rsp_ff.hit            <= touched_ff && ev_hit_ff;
         rsp_ff.miss           <= fill;
         rsp_ff.eviction       <= fill && ev_evict_ff;
         rsp_ff.way_used       <= touched_ff ? 3'(ev_way_ff) : 3'd0;
         rsp_ff.hit_total      <= hit_cnt_in;
         rsp_ff.miss_total     <= miss_cnt_in;
         rsp_ff.eviction_total <= evict_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff    <= salc_pkg::SET_BITS_RST;
         ways_in_use_ff <= salc_pkg::WAYS_IN_USE_RST;
         block_bits_ff  <= salc_pkg::BLOCK_BITS_RST;
         hit_cnt_ff     <= '0;
         miss_cnt_ff    <= '0;
         evict_cnt_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
         clr_idx_ff     <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               salc_pkg::CSR_SET_BITS:    set_bits_ff    <= csr_wdata[2:0];
               salc_pkg::CSR_WAYS_IN_USE: ways_in_use_ff <= csr_wdata[3:0];
               salc_pkg::CSR_BLOCK_BITS:  block_bits_ff  <= csr_wdata;
               default: ;
            endcase
         end
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         evict_cnt_ff <= evict_cnt_in;
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.clear_step) begin
            clr_idx_ff <= clr_idx_ff + SET_IDX_W'(1);
         end
      end
   end

   assign status.clear_last = (clr_idx_ff == SET_IDX_W'(NSETS - 1));
   assign status.out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data          = rsp_ff;

endmodule

`default_nettype wire

### rtl/core/salc_checker.sv
// port-level checks for the cache simulator and their bind to the top level
`default_nettype none

module salc_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire salc_pkg::rsp_word_type rsp_data
);

   // clearing pass keeps the input closed right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("req_ready high right after reset");

   // one access at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second word accepted while an access is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result word dropped or changed while stalled");

   // flags agree: a touched access is exactly one of hit or miss, eviction only on a miss
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.touched == (rsp_data.hit ^ rsp_data.miss)) &&
                     !(rsp_data.hit && rsp_data.miss) &&
                     (!rsp_data.eviction || rsp_data.miss)))
      else $error("inconsistent hit, miss and eviction flags");

endmodule

bind set_assoc_lru_cache_sim salc_checker u_salc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

### tb/set_assoc_lru_cache_sim_test.sv
// self-checking testbench for the set-associative lru cache simulator
`timescale 1ns / 100ps

module set_assoc_lru_cache_sim_test;

   localparam int SET_CNT     = 1 << salc_pkg::MAX_SET_BITS_DEF;
   localparam int LINE_CNT    = SET_CNT * salc_pkg::WAYS_DEF;
   localparam int STALL_LIMIT = 3000;
   localparam int PHASE_ITEMS = 102;

   // shadow copy of the cache that predicts every result word
   class lru_shadow_cache;
      bit          way_valid [LINE_CNT];
      bit [31:0]   way_tag   [LINE_CNT];
      bit [2:0]    way_age   [LINE_CNT];
      bit [31:0]   hit_tally;
      bit [31:0]   miss_tally;
      bit [31:0]   evict_count;
      logic [2:0]  cfg_set_bits;
      logic [3:0]  cfg_ways;
      logic [4:0]  cfg_block_bits;
      salc_pkg::rsp_word_type predicted [$];
      int          mismatch_count;

      function new();
         cfg_set_bits   = salc_pkg::SET_BITS_RST;
         cfg_ways       = salc_pkg::WAYS_IN_USE_RST;
         cfg_block_bits = salc_pkg::BLOCK_BITS_RST;
         hit_tally      = '0;
         miss_tally     = '0;
         evict_count    = '0;
         mismatch_count = 0;
      endfunction

      function void set_reg(logic [salc_pkg::CSR_IDX_W-1:0] idx,
                            logic [salc_pkg::CSR_DATA_W-1:0] val);
         case (idx)
            salc_pkg::CSR_SET_BITS:    cfg_set_bits   = val[2:0];
            salc_pkg::CSR_WAYS_IN_USE: cfg_ways       = val[3:0];
            salc_pkg::CSR_BLOCK_BITS:  cfg_block_bits = val[4:0];
            default: ;
         endcase
      endfunction

      function bit [31:0] bump(bit [31:0] v);
         return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
      endfunction

      // accessed way becomes newest, younger valid ways age by one
      function void make_newest(int base, int ways, int way, int old_age);
         for (int i = 0; i < ways; i++) begin
            if (i != way && way_valid[base + i] && way_age[base + i] < old_age &&
                way_age[base + i] < salc_pkg::WAYS_DEF - 1)
               way_age[base + i]++;
         end
         way_age[base + way] = 0;
      endfunction

      function void accept_access(salc_pkg::req_word_type w);
         salc_pkg::rsp_word_type r;
         int          s_eff, ways, sh, base, way;
         bit [63:0]   addr;
         bit [31:0]   tag;
         bit          found, empty;
         r = '0;
         if (w.func == salc_pkg::FUNC_LOAD || w.func == salc_pkg::FUNC_STORE) begin
            s_eff = (int'(cfg_set_bits) > salc_pkg::MAX_SET_BITS_DEF) ?
                    salc_pkg::MAX_SET_BITS_DEF : int'(cfg_set_bits);
            ways  = (cfg_ways == 0) ? 1 : ((int'(cfg_ways) > salc_pkg::WAYS_DEF) ?
                                           salc_pkg::WAYS_DEF : int'(cfg_ways));
            sh    = s_eff + int'(cfg_block_bits);
            addr  = {32'b0, w.address & salc_pkg::ADDR_MASK};
            base  = int'((addr >> cfg_block_bits) & ((64'd1 << s_eff) - 64'd1)) *
                    salc_pkg::WAYS_DEF;
            tag   = 32'(addr >> sh);
            found = 0;
            way   = 0;
            r.touched = 1'b1;
            for (int i = 0; i < ways; i++) begin
               if (!found && way_valid[base + i] && way_tag[base + i] == tag) begin
                  found = 1;
                  way   = i;
               end
            end
            if (found) begin
               r.hit     = 1'b1;
               hit_tally = bump(hit_tally);
               make_newest(base, ways, way, int'(way_age[base + way]));
            end else begin
               r.miss     = 1'b1;
               miss_tally = bump(miss_tally);
               empty      = 0;
               for (int i = 0; i < ways; i++) begin
                  if (!empty && !way_valid[base + i]) begin
                     empty = 1;
                     way   = i;
                  end
               end
               if (!empty) begin
                  r.eviction  = 1'b1;
                  evict_count = bump(evict_count);
                  way         = 0;
                  for (int i = 1; i < ways; i++)
                     if (way_age[base + i] > way_age[base + way])
                        way = i;
               end
               way_valid[base + way] = 1'b1;
               way_tag[base + way]   = tag;
               // a fill ages every other valid way in use, up to the oldest age
               make_newest(base, ways, way, salc_pkg::WAYS_DEF);
            end
            r.way_used = way[2:0];
         end
         r.hit_total      = hit_tally;
         r.miss_total     = miss_tally;
         r.eviction_total = evict_count;
         predicted.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
         end
      endfunction

      function void check_rsp(salc_pkg::rsp_word_type got);
         salc_pkg::rsp_word_type want;
         if (predicted.size() == 0) begin
            $error("result word with no access pending: %0h", got);
            mismatch_count++;
            return;
         end
         want = predicted.pop_front();
         compare_field("touched", 32'(want.touched), 32'(got.touched));
         compare_field("hit", 32'(want.hit), 32'(got.hit));
         compare_field("miss", 32'(want.miss), 32'(got.miss));
         compare_field("eviction", 32'(want.eviction), 32'(got.eviction));
         compare_field("way_used", 32'(want.way_used), 32'(got.way_used));
         compare_field("hit_total", want.hit_total, got.hit_total);
         compare_field("miss_total", want.miss_total, got.miss_total);
         compare_field("eviction_total", want.eviction_total, got.eviction_total);
      endfunction

      function int pending();
         return predicted.size();
      endfunction
   endclass

   logic                            clock     = 1'b0;
   logic                            reset     = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   salc_pkg::req_word_type          req_data  = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   salc_pkg::rsp_word_type          rsp_data;
   logic                            csr_we    = 1'b0;
   logic [salc_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [salc_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   lru_shadow_cache sb = new();
   int results_seen = 0;
   int idle_cycles  = 0;

   int phase_sets   [10] = '{0, 6, 7, 3, 6, 1, 5, 7, 2, 4};
   int phase_ways   [10] = '{8, 8, 15, 0, 1, 8, 5, 9, 3, 2};
   int phase_blocks [10] = '{0, 26, 31, 5, 0, 31, 10, 3, 28, 12};

   set_assoc_lru_cache_sim uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         sb.check_rsp(rsp_data);
         results_seen <= results_seen + 1;
      end
      if (req_valid && req_ready)
         sb.accept_access(req_data);
      if ((rsp_valid && rsp_ready) || (req_valid && req_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < STALL_LIMIT)
         @(posedge clock);
      $display("== FAIL ==");
      $finish;
   end

   // result side pacing, with one long hold-off that backs the block up
   initial begin
      int len, pick;
      bit long_done;
      long_done = 0;
      @(posedge clock);
      forever begin
         pick = $urandom_range(0, 99);
         if (!long_done && results_seen >= 300) begin
            long_done = 1;
            rsp_ready <= 1'b0;
            len = 400;
         end else if (pick < 60) begin
            rsp_ready <= 1'b1;
            len = $urandom_range(1, 20);
         end else if (pick < 90) begin
            rsp_ready <= 1'b0;
            len = $urandom_range(1, 3);
         end else if (pick < 98) begin
            rsp_ready <= 1'b0;
            len = $urandom_range(4, 12);
         end else begin
            rsp_ready <= 1'b0;
            len = $urandom_range(20, 60);
         end
         repeat (len) @(posedge clock);
      end
   end

   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] compose_addr(logic [31:0] tag, int set_idx, int s_eff,
                                                logic [4:0] b);
      logic [63:0] a;
      a = ({32'b0, tag} << (s_eff + b)) | (64'(set_idx) << b) |
          (64'($urandom()) & ((64'd1 << b) - 64'd1));
      return a[31:0];
   endfunction

   // returns in the step where the word was taken, valid still high
   task automatic send_access(input logic [1:0] func, input logic [31:0] addr, input bit steady);
      int gap;
      salc_pkg::req_word_type w;
      gap = steady ? 0 : pick_gap();
      w.func    = func;
      w.address = addr;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_geometry(input logic [2:0] s, input logic [3:0] w, input logic [4:0] b);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= salc_pkg::CSR_SET_BITS;
      csr_wdata <= {2'b0, s};
      @(posedge clock);
      csr_index <= salc_pkg::CSR_WAYS_IN_USE;
      csr_wdata <= {1'b0, w};
      @(posedge clock);
      csr_index <= salc_pkg::CSR_BLOCK_BITS;
      csr_wdata <= b;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_reg(salc_pkg::CSR_SET_BITS, {2'b0, s});
      sb.set_reg(salc_pkg::CSR_WAYS_IN_USE, {1'b0, w});
      sb.set_reg(salc_pkg::CSR_BLOCK_BITS, b);
   endtask

   initial begin
      int          s_eff, ways_eff, n_tags, sent, pick;
      logic [31:0] tag_pool [10];
      int          set_pool [3];
      logic [2:0]  s;
      logic [3:0]  w;
      logic [4:0]  b;
      logic [1:0]  func;
      logic [31:0] addr;
      bit          steady;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset geometry: 16 sets, one way, 16-byte blocks
      send_access(salc_pkg::FUNC_INSTR, 32'hFFFF_FFFF, 1'b0);
      send_access(salc_pkg::FUNC_MODIFY, 32'h0000_0000, 1'b0);
      send_access(salc_pkg::FUNC_LOAD, 32'h0000_0000, 1'b0);
      send_access(salc_pkg::FUNC_STORE, 32'h0000_000F, 1'b0);
      send_access(salc_pkg::FUNC_LOAD, 32'h0000_0100, 1'b0);
      send_access(salc_pkg::FUNC_LOAD, 32'hFFFF_FFFF, 1'b0);
      send_access(salc_pkg::FUNC_STORE, 32'hFFFF_FFF0, 1'b0);
      send_access(salc_pkg::FUNC_MODIFY, 32'hFFFF_FFFF, 1'b0);
      wait_idle();

      // four ways in set 1: fill, reuse, then replace the oldest
      write_geometry(3'd2, 4'd4, 5'd2);
      for (int t = 0; t < 4; t++)
         send_access(salc_pkg::FUNC_LOAD, 32'(t * 16 + 4), 1'b0);
      send_access(salc_pkg::FUNC_STORE, 32'h0000_0004, 1'b0);
      send_access(salc_pkg::FUNC_LOAD, 32'h0000_0044, 1'b0);
      send_access(salc_pkg::FUNC_LOAD, 32'h0000_0014, 1'b0);
      send_access(salc_pkg::FUNC_STORE, 32'h0000_0004, 1'b1);
      send_access(salc_pkg::FUNC_STORE, 32'h0000_0034, 1'b1);
      send_access(salc_pkg::FUNC_LOAD, 32'h0000_0054, 1'b1);
      send_access(salc_pkg::FUNC_INSTR, 32'h0000_0004, 1'b0);
      send_access(salc_pkg::FUNC_LOAD, 32'hFFFF_FFFF, 1'b0);
      send_access(salc_pkg::FUNC_STORE, 32'h0000_0000, 1'b0);

      for (int p = 0; p < 12; p++) begin
         wait_idle();
         if (p < 10) begin
            s = 3'(phase_sets[p]);
            w = 4'(phase_ways[p]);
            b = 5'(phase_blocks[p]);
         end else begin
            s = 3'($urandom_range(0, 7));
            w = 4'($urandom_range(0, 15));
            b = 5'($urandom_range(0, 31));
         end
         write_geometry(s, w, b);
         s_eff    = (int'(s) > salc_pkg::MAX_SET_BITS_DEF) ?
                    salc_pkg::MAX_SET_BITS_DEF : int'(s);
         ways_eff = (w == 0) ? 1 : ((int'(w) > salc_pkg::WAYS_DEF) ?
                                    salc_pkg::WAYS_DEF : int'(w));
         // a few more tags than ways keeps hits and replacements both common
         n_tags   = ways_eff + 2;
         for (int i = 0; i < n_tags; i++)
            tag_pool[i] = $urandom();
         for (int i = 0; i < 3; i++)
            set_pool[i] = $urandom_range(0, (1 << s_eff) - 1);
         steady = ($urandom_range(0, 2) == 0);
         sent   = 0;
         while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
               func = $urandom_range(0, 1) ? salc_pkg::FUNC_INSTR : salc_pkg::FUNC_MODIFY;
            else
               func = pick[0] ? salc_pkg::FUNC_LOAD : salc_pkg::FUNC_STORE;
            if ($urandom_range(0, 99) < 82)
               addr = compose_addr(tag_pool[$urandom_range(0, n_tags - 1)],
                                   set_pool[$urandom_range(0, 2)], s_eff, b);
            else
               addr = $urandom();
            send_access(func, addr, steady);
            if (func == salc_pkg::FUNC_LOAD || func == salc_pkg::FUNC_STORE)
               sent++;
         end
      end
      wait_idle();

      if (sb.mismatch_count == 0 && sb.pending() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

### set_assoc_lru_cache_sim.f
rtl/core/salc_pkg.sv
rtl/core/salc_ctrl.sv
rtl/core/salc_dpath.sv
rtl/core/set_assoc_lru_cache_sim.sv
rtl/core/salc_checker.sv
tb/set_assoc_lru_cache_sim_test.sv
